[design/datot_pkg.sv]
// Shared types and constants for the daily alarm table with output timer.
// Used by datot_ctrl, datot_dp and the core top level; no dependencies.
`default_nettype none

package datot_pkg;

    localparam int IN_W  = 88;
    localparam int OUT_W = 48;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_EDIT   = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_TEMP   = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;
    localparam logic [2:0] MODE_HOLD   = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_HELD    = 3'd4;

    localparam logic [7:0] TEMP_ID_HI = 8'hFF;
    localparam logic [9:0] MS_PER_S   = 10'd1000;
    localparam logic [5:0] FIRE_WIN_S = 6'd5;

    typedef struct packed {
        logic [15:0] id;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] dur;
        logic        en;
        logic        fired_vld;
        logic [4:0]  fired_day;
        logic [5:0]  fired_min;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       sh_init;
        logic       sh_rd;
        logic       sh_wr;
        logic       dec;
        logic       wr_new;
        logic       wr_edit;
        logic       wr_fire;
        logic       tick_end;
        logic       hold_we;
        logic       st_we;
        logic [2:0] st_code;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       hold;
        logic       scan_hit;
        logic       scan_done;
        logic       sh_more;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

[design/datot_dp.sv]
// Datapath: item latch, alarm table memory, scan/shift pointers, output timer
// and result register. Driven by datot_ctrl; uses datot_pkg.
`default_nettype none

module datot_dp
    import datot_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IN_W-1:0]  i_s_tdata,
    input  wire logic [2:0]       i_s_tuser,
    input  wire logic             i_m_tready,
    input  wire t_cmd             i_cmd,
    output t_stat                 o_stat,
    output logic                  o_m_tvalid,
    output logic [OUT_W-1:0]      o_m_tdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    logic [2:0]  r_mode;
    logic [15:0] r_id;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;
    logic [4:0]  r_day;
    logic [15:0] r_dur;
    logic        r_en;
    logic [31:0] r_now;

    t_entry          r_mem [MAX_ENTRIES];
    t_entry          r_rd_data;
    logic [AW-1:0]   r_rd_idx;
    logic            r_rd_vld;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_count;
    logic [7:0]      r_temp;
    logic            r_out_act;
    logic [31:0]     r_out_end;
    logic            r_hold;
    logic [25:0]     r_prod;

    logic [2:0]      r_status;
    logic            r_fired;
    logic [15:0]     r_fired_id;
    logic [15:0]     r_assigned;

    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;

    logic            w_scan_issue;
    logic            w_re;
    logic [AW-1:0]   w_ra;
    logic            w_we;
    logic [AW-1:0]   w_wa;
    t_entry          w_wd;
    logic [CW:0]     w_idx_inc;
    logic            w_id_match;
    logic            w_fire_match;
    logic            w_hit;
    logic [15:0]     w_new_id;
    logic [31:0]     w_end;
    logic            w_act;

    // Item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_s_tuser;
            r_id   <= i_s_tdata[15:0];
            r_hour <= i_s_tdata[20:16];
            r_min  <= i_s_tdata[26:21];
            r_sec  <= i_s_tdata[32:27];
            r_day  <= i_s_tdata[37:33];
            r_dur  <= i_s_tdata[53:38];
            r_en   <= i_s_tdata[54];
            r_now  <= i_s_tdata[86:55];
        end
    end

    // Table access
    always_comb begin
        w_idx_inc    = {1'b0, r_idx} + (CW + 1)'(1);
        w_scan_issue = i_cmd.scan && (r_idx < r_count);
        w_re         = w_scan_issue || i_cmd.sh_rd;
        w_ra         = i_cmd.sh_rd ? w_idx_inc[AW-1:0] : r_idx[AW-1:0];
        w_new_id     = (r_mode == MODE_TEMP) ? {TEMP_ID_HI, r_temp} : r_id;
        w_we         = i_cmd.wr_new || i_cmd.wr_edit || i_cmd.wr_fire || i_cmd.sh_wr;

        w_wa = r_rd_idx;
        w_wd = r_rd_data;
        if (i_cmd.wr_new) begin
            w_wa           = r_count[AW-1:0];
            w_wd.id        = w_new_id;
            w_wd.hour      = r_hour;
            w_wd.minute    = r_min;
            w_wd.dur       = r_dur;
            w_wd.en        = r_en;
            w_wd.fired_vld = 1'b0;
            w_wd.fired_day = '0;
            w_wd.fired_min = '0;
        end else if (i_cmd.wr_edit) begin
            w_wd.hour   = r_hour;
            w_wd.minute = r_min;
            w_wd.dur    = r_dur;
            w_wd.en     = r_en;
        end else if (i_cmd.wr_fire) begin
            w_wd.fired_vld = 1'b1;
            w_wd.fired_day = r_day;
            w_wd.fired_min = r_min;
        end else if (i_cmd.sh_wr) begin
            w_wa = r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
            r_rd_idx  <= w_ra;
        end
    end

    // Match logic on the entry just read
    always_comb begin
        w_id_match   = (r_rd_data.id == r_id);
        w_fire_match = r_rd_data.en
                    && !(r_rd_data.fired_vld && (r_rd_data.fired_day == r_day)
                         && (r_rd_data.fired_min == r_min))
                    && (r_rd_data.hour == r_hour) && (r_rd_data.minute == r_min)
                    && (r_sec < FIRE_WIN_S);
        w_hit        = (r_mode == MODE_TICK) ? w_fire_match : w_id_match;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (w_scan_issue) begin
            r_idx <= w_idx_inc[CW-1:0];
        end else if (i_cmd.sh_init) begin
            r_idx <= CW'(r_rd_idx);
        end else if (i_cmd.sh_wr) begin
            r_idx <= w_idx_inc[CW-1:0];
        end
        if (i_cmd.wr_fire) begin
            r_prod <= 26'(r_rd_data.dur) * 26'(MS_PER_S);
        end
    end

    // Output timer: fire sets the end time, then the off check
    always_comb begin
        w_end = r_fired ? (r_now + 32'(r_prod)) : r_out_end;
        w_act = r_fired || r_out_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_temp    <= '0;
            r_out_act <= 1'b0;
            r_out_end <= '0;
            r_hold    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_rd_vld <= w_scan_issue;
            if (i_cmd.wr_new) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.wr_new && (r_mode == MODE_TEMP)) begin
                r_temp <= r_temp + 8'd1;
            end
            if (i_cmd.tick_end) begin
                r_out_end <= w_end;
                r_out_act <= w_act && !(r_now >= w_end);
            end
            if (i_cmd.hold_we) begin
                r_hold <= r_en;
            end
            if (i_cmd.emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= ST_OK;
            r_fired    <= 1'b0;
            r_fired_id <= '0;
            r_assigned <= '0;
        end else begin
            if (i_cmd.st_we) begin
                r_status <= i_cmd.st_code;
            end
            if (i_cmd.wr_new && (r_mode == MODE_TEMP)) begin
                r_assigned <= w_new_id;
            end
            if (i_cmd.wr_fire) begin
                r_fired    <= 1'b1;
                r_fired_id <= r_rd_data.id;
            end
        end
        if (i_cmd.emit) begin
            r_m_data <= {6'd0, r_assigned, r_fired_id, r_fired, r_out_act,
                         5'(r_count), r_status};
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.full      = (r_count >= MAX_C);
        o_stat.hold      = r_hold;
        o_stat.scan_hit  = r_rd_vld && w_hit;
        o_stat.scan_done = !r_rd_vld && !(r_idx < r_count);
        o_stat.sh_more   = (w_idx_inc < {1'b0, r_count});
        o_stat.out_free  = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_C)
        else $error("entry count above table depth");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_new |-> (r_count < MAX_C))
        else $error("append into a full table");

    a_upd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_edit || i_cmd.wr_fire) |-> (CW'(r_rd_idx) < r_count))
        else $error("entry update beyond live entries");

    a_held_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_status == ST_HELD)) |-> !r_fired)
        else $error("held tick reported a firing");
`endif

endmodule

`default_nettype wire

[design/datot_ctrl.sv]
// Controller: one-hot sequencer for add, edit, remove, temporary add, tick
// and hold items. Commands datot_dp through t_cmd; uses datot_pkg.
`default_nettype none

module datot_ctrl
    import datot_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHRD  = 7'b0001000,
        S_SHWR  = 7'b0010000,
        S_TIMER = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (i_stat.mode)
                    MODE_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    MODE_EDIT, MODE_REMOVE: begin
                        n_state = S_SCAN;
                    end
                    MODE_TEMP: begin
                        if (i_stat.full) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.wr_new = 1'b1;
                        end
                    end
                    MODE_TICK: begin
                        if (i_stat.hold) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_HELD;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    MODE_HOLD: begin
                        o_cmd.hold_we = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = S_DONE;
                    case (i_stat.mode)
                        MODE_ADD: begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_DUP;
                        end
                        MODE_EDIT: begin
                            o_cmd.wr_edit = 1'b1;
                        end
                        MODE_REMOVE: begin
                            o_cmd.sh_init = 1'b1;
                            n_state       = S_SHRD;
                        end
                        default: begin
                            o_cmd.wr_fire = 1'b1;
                            n_state       = S_TIMER;
                        end
                    endcase
                end else if (i_stat.scan_done) begin
                    n_state = S_DONE;
                    case (i_stat.mode)
                        MODE_ADD: begin
                            o_cmd.wr_new = 1'b1;
                        end
                        MODE_EDIT, MODE_REMOVE: begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_MISSING;
                        end
                        default: begin
                            n_state = S_TIMER;
                        end
                    endcase
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SHRD: begin
                if (i_stat.sh_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SHWR;
                end else begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_SHWR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SHRD;
            end
            S_TIMER: begin
                o_cmd.tick_end = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[design/daily_alarm_table_with_output_timer_core.sv]
// Top level of the daily alarm table with output timer.
// Instantiates datot_ctrl and datot_dp; uses datot_pkg.
//
// One item is taken at a time and answered with one result transfer. The table
// sits in a memory with separate read and write addresses that is walked one
// entry per cycle by the scan. Hold, held-tick, full and temporary-add items
// need no scan; add, edit and tick scan the live entries, and a remove that
// matches then moves each later entry down by one, with a read and a write for
// each. A result that waits on the receiver holds the sequencer in its done
// state. No clearing pass is needed after reset; the result register lets the
// next item start while a result still waits.
`default_nettype none

module daily_alarm_table_with_output_timer_core
    import datot_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // alarm_id[15:0] hour[20:16] minute[26:21] second[32:27] day[37:33]
    // duration_s[53:38] enable[54] now_ms[86:55], zero pad[87]
    input  wire logic [IN_W-1:0]  i_s_tdata,
    // mode[2:0]
    input  wire logic [2:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // status[2:0] entry_count[7:3] output_on[8] fired[9] fired_id[25:10]
    // assigned_id[41:26], zero pad[47:42]
    output logic [OUT_W-1:0]      o_m_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    datot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    datot_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
